// ===== hw/rtl/source_text_tokenizer_macros.svh =====
// ---------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared property wrappers for the tokenizer checkers.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication
`define STT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== hw/rtl/stt_pkg.sv =====
// ---------------------------------------------------------------------------
// Tokenizer package
// Token kinds, scan modes, keyword table and shared record types.
// ---------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int MAX_TOKEN_LEN = 65535;
  localparam int KEYWORD_COUNT = 9;
  localparam int KW_MAX        = 9;
  localparam int KW_USED       = (KEYWORD_COUNT < KW_MAX) ? KEYWORD_COUNT : KW_MAX;
  localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN < 65535) ? MAX_TOKEN_LEN : 65535;
  localparam logic [15:0] LEN_CAP = 16'(LEN_CAP_INT);
  localparam logic [KW_MAX-1:0] KW_MASK = KW_MAX'((64'd1 << KW_USED) - 64'd1);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [5:0] KIND_EOF     = 6'd0;
  localparam logic [5:0] KIND_IDENT   = 6'd1;
  localparam logic [5:0] KIND_INT     = 6'd2;
  localparam logic [5:0] KIND_STR     = 6'd3;
  localparam logic [5:0] KIND_CHR     = 6'd4;
  localparam logic [5:0] KIND_KW_BASE = 6'd5;
  localparam logic [5:0] KIND_LBRACE  = 6'd14;
  localparam logic [5:0] KIND_RBRACE  = 6'd15;
  localparam logic [5:0] KIND_LPAREN  = 6'd16;
  localparam logic [5:0] KIND_RPAREN  = 6'd17;
  localparam logic [5:0] KIND_SEMI    = 6'd18;
  localparam logic [5:0] KIND_COMMA   = 6'd19;
  localparam logic [5:0] KIND_DOT     = 6'd20;
  localparam logic [5:0] KIND_PLUS    = 6'd21;
  localparam logic [5:0] KIND_MINUS   = 6'd22;
  localparam logic [5:0] KIND_STAR    = 6'd23;
  localparam logic [5:0] KIND_SLASH   = 6'd24;
  localparam logic [5:0] KIND_ASSIGN  = 6'd25;
  localparam logic [5:0] KIND_EQEQ    = 6'd26;
  localparam logic [5:0] KIND_NE      = 6'd27;
  localparam logic [5:0] KIND_GT      = 6'd28;
  localparam logic [5:0] KIND_GE      = 6'd29;
  localparam logic [5:0] KIND_LT      = 6'd30;
  localparam logic [5:0] KIND_LE      = 6'd31;
  localparam logic [5:0] KIND_UNKNOWN = 6'd32;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUM, MODE_STR, MODE_CHR,
    MODE_EQ, MODE_BANG, MODE_GT, MODE_LT
  } scan_mode_e;

  localparam logic [3:0] KW_LEN [KW_MAX] = '{
    4'd4, 4'd6, 4'd7, 4'd7, 4'd2, 4'd4, 4'd5, 4'd3, 4'd8
  };

  localparam logic [7:0] KW_CHARS [KW_MAX][8] = '{
    '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"s", "u", "c", "c", "e", "s", "s", 8'h00},
    '{"f", "a", "i", "l", "u", "r", "e", 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"#", "i", "n", "c", "l", "u", "d", "e"}
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] length;
    logic [31:0] offset;
    logic [15:0] line;
    logic [15:0] column;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } pair_t;

  function automatic logic [KW_MAX-1:0] kw_keep(input logic [15:0] idx,
                                                input logic [7:0] b);
    logic [KW_MAX-1:0] keep;
    keep = '0;
    for (int k = 0; k < KW_MAX; k++) begin
      keep[k] = (k < KW_USED) && (idx < {12'd0, KW_LEN[k]}) &&
                (KW_CHARS[k][idx[2:0]] == b);
    end
    return keep;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [KW_MAX-1:0] alive,
                                            input logic [15:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int k = KW_MAX - 1; k >= 0; k--) begin
      if ((k < KW_USED) && alive[k] && (len == {12'd0, KW_LEN[k]})) begin
        kind = KIND_KW_BASE + 6'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] kind;
    case (b)
      "{": kind = KIND_LBRACE;
      "}": kind = KIND_RBRACE;
      "(": kind = KIND_LPAREN;
      ")": kind = KIND_RPAREN;
      ";": kind = KIND_SEMI;
      ",": kind = KIND_COMMA;
      ".": kind = KIND_DOT;
      "+": kind = KIND_PLUS;
      "-": kind = KIND_MINUS;
      "*": kind = KIND_STAR;
      "/": kind = KIND_SLASH;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stt_scanner.sv =====
// ---------------------------------------------------------------------------
// Tokenizer scanner
// Classifies each accepted byte, tracks the pending token and position, and
// forms the one or two tokens that the byte completes.
// ---------------------------------------------------------------------------
`default_nettype none

module stt_scanner (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    text_byte_i,
  output stt_pkg::pair_t     pair_o,
  output logic               pair_valid_o
);

  stt_pkg::scan_mode_e          mode_q, mode_d;
  logic [stt_pkg::KW_MAX-1:0]   alive_q, alive_d;
  logic [15:0]                  plen_q, plen_d;
  logic [31:0]                  poff_q, poff_d;
  logic [15:0]                  pline_q, pline_d;
  logic [15:0]                  pcol_q, pcol_d;
  logic [31:0]                  boff_q, boff_d;
  logic [15:0]                  line_q, line_d;
  logic [15:0]                  col_q, col_d;
  logic                         ended_q, ended_d;

  logic [7:0]     b;
  logic           is_alpha, is_digit, is_space, is_ident;
  logic [15:0]    grown;
  logic           fresh, do_adv;
  logic           emit_a, emit_b;
  stt_pkg::token_t tok_a, tok_b;

  assign b        = text_byte_i;
  assign is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  assign is_digit = (b >= "0" && b <= "9");
  assign is_space = (b == " ") || (b >= 8'd9 && b <= 8'd13);
  assign is_ident = is_alpha || is_digit || (b == "_");
  assign grown    = (plen_q < stt_pkg::LEN_CAP) ? plen_q + 16'd1 : plen_q;

  always_comb begin
    mode_d  = mode_q;
    alive_d = alive_q;
    plen_d  = plen_q;
    poff_d  = poff_q;
    pline_d = pline_q;
    pcol_d  = pcol_q;
    boff_d  = boff_q;
    line_d  = line_q;
    col_d   = col_q;
    ended_d = ended_q;
    fresh   = 1'b1;
    do_adv  = 1'b0;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    tok_a   = '{kind: stt_pkg::KIND_EOF, length: plen_q, offset: poff_q,
                line: pline_q, column: pcol_q};
    tok_b   = '{kind: stt_pkg::KIND_EOF, length: 16'd0, offset: boff_q,
                line: line_q, column: col_q};

    case (mode_q)
      stt_pkg::MODE_IDENT: begin
        if (is_ident) begin
          alive_d = alive_q & stt_pkg::kw_keep(plen_q, b);
          plen_d  = grown;
          do_adv  = 1'b1;
          fresh   = 1'b0;
        end else begin
          emit_a     = 1'b1;
          tok_a.kind = stt_pkg::ident_kind(alive_q, plen_q);
          mode_d     = stt_pkg::MODE_IDLE;
          alive_d    = stt_pkg::KW_MASK;
        end
      end
      stt_pkg::MODE_NUM: begin
        if (is_digit) begin
          plen_d = grown;
          do_adv = 1'b1;
          fresh  = 1'b0;
        end else begin
          emit_a     = 1'b1;
          tok_a.kind = stt_pkg::KIND_INT;
          mode_d     = stt_pkg::MODE_IDLE;
        end
      end
      stt_pkg::MODE_STR, stt_pkg::MODE_CHR: begin
        tok_a.kind = (mode_q == stt_pkg::MODE_STR) ? stt_pkg::KIND_STR : stt_pkg::KIND_CHR;
        if (b == 8'h00) begin
          emit_a = 1'b1;
          mode_d = stt_pkg::MODE_IDLE;
        end else begin
          plen_d = grown;
          do_adv = 1'b1;
          fresh  = 1'b0;
          if ((mode_q == stt_pkg::MODE_STR && b == "\"") ||
              (mode_q == stt_pkg::MODE_CHR && b == "'")) begin
            emit_a       = 1'b1;
            tok_a.length = grown;
            mode_d       = stt_pkg::MODE_IDLE;
          end
        end
      end
      stt_pkg::MODE_EQ, stt_pkg::MODE_BANG, stt_pkg::MODE_GT, stt_pkg::MODE_LT: begin
        emit_a = 1'b1;
        mode_d = stt_pkg::MODE_IDLE;
        if (b == "=") begin
          plen_d       = 16'd2;
          tok_a.length = 16'd2;
          do_adv       = 1'b1;
          fresh        = 1'b0;
          case (mode_q)
            stt_pkg::MODE_EQ:   tok_a.kind = stt_pkg::KIND_EQEQ;
            stt_pkg::MODE_BANG: tok_a.kind = stt_pkg::KIND_NE;
            stt_pkg::MODE_GT:   tok_a.kind = stt_pkg::KIND_GE;
            default:            tok_a.kind = stt_pkg::KIND_LE;
          endcase
        end else begin
          case (mode_q)
            stt_pkg::MODE_EQ:   tok_a.kind = stt_pkg::KIND_ASSIGN;
            stt_pkg::MODE_BANG: tok_a.kind = stt_pkg::KIND_UNKNOWN;
            stt_pkg::MODE_GT:   tok_a.kind = stt_pkg::KIND_GT;
            default:            tok_a.kind = stt_pkg::KIND_LT;
          endcase
        end
      end
      default: begin
        mode_d = stt_pkg::MODE_IDLE;
      end
    endcase

    if (fresh) begin
      if (b == 8'h00) begin
        emit_b  = 1'b1;
        ended_d = 1'b1;
      end else if (is_space) begin
        do_adv = 1'b1;
      end else begin
        do_adv  = 1'b1;
        plen_d  = 16'd1;
        poff_d  = boff_q;
        pline_d = line_q;
        pcol_d  = col_q;
        if (is_alpha || b == "_" || b == "#") begin
          mode_d  = stt_pkg::MODE_IDENT;
          alive_d = stt_pkg::KW_MASK & stt_pkg::kw_keep(16'd0, b);
        end else if (is_digit) begin
          mode_d = stt_pkg::MODE_NUM;
        end else if (b == "\"") begin
          mode_d = stt_pkg::MODE_STR;
        end else if (b == "'") begin
          mode_d = stt_pkg::MODE_CHR;
        end else if (b == "=") begin
          mode_d = stt_pkg::MODE_EQ;
        end else if (b == "!") begin
          mode_d = stt_pkg::MODE_BANG;
        end else if (b == ">") begin
          mode_d = stt_pkg::MODE_GT;
        end else if (b == "<") begin
          mode_d = stt_pkg::MODE_LT;
        end else begin
          plen_d       = plen_q;
          poff_d       = poff_q;
          pline_d      = pline_q;
          pcol_d       = pcol_q;
          emit_b       = 1'b1;
          tok_b.kind   = stt_pkg::single_kind(b);
          tok_b.length = 16'd1;
        end
      end
    end

    if (do_adv) begin
      boff_d = boff_q + 32'd1;
      if (b == "\n") begin
        line_d = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
        col_d  = 16'd1;
      end else begin
        col_d = (col_q != 16'hFFFF) ? col_q + 16'd1 : col_q;
      end
    end
  end

  always_comb begin
    pair_valid_o = accept_i && !ended_q && (emit_a || emit_b);
    pair_o.two   = emit_a && emit_b;
    pair_o.first = emit_a ? tok_a : tok_b;
    pair_o.second = tok_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      alive_q <= stt_pkg::KW_MASK;
      plen_q  <= 16'd0;
      poff_q  <= 32'd0;
      pline_q <= 16'd1;
      pcol_q  <= 16'd1;
      boff_q  <= 32'd0;
      line_q  <= 16'd1;
      col_q   <= 16'd1;
      ended_q <= 1'b0;
    end else if (accept_i && !ended_q) begin
      mode_q  <= mode_d;
      alive_q <= alive_d;
      plen_q  <= plen_d;
      poff_q  <= poff_d;
      pline_q <= pline_d;
      pcol_q  <= pcol_d;
      boff_q  <= boff_d;
      line_q  <= line_d;
      col_q   <= col_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_fifo.sv =====
// ---------------------------------------------------------------------------
// Tokenizer token queue
// Short queue of token pairs between the scanner and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module stt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire stt_pkg::pair_t pair_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output stt_pkg::pair_t      pair_o,
  output logic                empty_o
);

  stt_pkg::pair_t                 mem_q [stt_pkg::FIFO_DEPTH];
  logic [stt_pkg::PTR_W-1:0]      wptr_q, rptr_q;
  logic [stt_pkg::CNT_W-1:0]      cnt_q;
  logic                           do_push, do_pop;

  localparam logic [stt_pkg::PTR_W-1:0] LAST = stt_pkg::PTR_W'(stt_pkg::FIFO_DEPTH - 1);
  localparam logic [stt_pkg::CNT_W-1:0] FULL = stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH);
  localparam logic [stt_pkg::PTR_W-1:0] PTR_ONE = stt_pkg::PTR_W'(1);
  localparam logic [stt_pkg::CNT_W-1:0] CNT_ONE = stt_pkg::CNT_W'(1);

  assign full_o  = (cnt_q == FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pair_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PTR_ONE;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_ONE;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_ONE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_unpack.sv =====
// ---------------------------------------------------------------------------
// Tokenizer output stage
// Presents the queued token pairs one token per transfer and marks the last
// token caused by each byte.
// ---------------------------------------------------------------------------
`default_nettype none

module stt_unpack (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stt_pkg::pair_t pair_i,
  input  wire logic           pair_empty_i,
  output logic                pair_pop_o,
  input  wire logic           pop_i,
  output stt_pkg::token_t     token_o,
  output logic                last_o
);

  logic sel_q;
  logic take;

  assign token_o    = sel_q ? pair_i.second : pair_i.first;
  assign last_o     = sel_q || !pair_i.two;
  assign take       = pop_i && !pair_empty_i;
  assign pair_pop_o = take && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= !last_o;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/source_text_tokenizer.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer
// Streams source bytes in, emits tokens with kind, length and start position.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  text in  | push / full        | text_byte_i
//  tokens   | empty / pop        | token_kind_o, token_length_o, start_offset_o,
//           |                    | start_line_o, start_column_o, last_of_run_o
//
//  One byte is taken per cycle while the four-entry pair queue has room.
//  A token is queued as its closing byte is taken and shown at the queue head.
//  A byte that closes one token and completes another yields two tokens, sent
//  on two transfers; the output stage sustains one token a cycle while popped.
//  Reset clears the scanner position, pending token and queue at once.
//  A stalled output holds its token; full rises only when the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       token_kind_o,
  output logic [15:0]      token_length_o,
  output logic [31:0]      start_offset_o,
  output logic [15:0]      start_line_o,
  output logic [15:0]      start_column_o,
  output logic             last_of_run_o
);

  stt_pkg::pair_t  scan_pair, head_pair;
  stt_pkg::token_t token;
  logic            scan_valid, fifo_full, fifo_empty, fifo_pop, accept;

  assign accept = push && !fifo_full;
  assign full   = fifo_full;
  assign empty  = fifo_empty;

  stt_scanner u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .pair_o       (scan_pair),
    .pair_valid_o (scan_valid)
  );

  stt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (scan_valid),
    .pair_i  (scan_pair),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .pair_o  (head_pair),
    .empty_o (fifo_empty)
  );

  stt_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (head_pair),
    .pair_empty_i (fifo_empty),
    .pair_pop_o   (fifo_pop),
    .pop_i        (pop),
    .token_o      (token),
    .last_o       (last_of_run_o)
  );

  assign token_kind_o   = token.kind;
  assign token_length_o = token.length;
  assign start_offset_o = token.offset;
  assign start_line_o   = token.line;
  assign start_column_o = token.column;

endmodule

`default_nettype wire

// ===== hw/rtl/stt_checker.sv =====
// ---------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top-level ports and flags token stream inconsistencies.
// ---------------------------------------------------------------------------
`default_nettype none

`include "source_text_tokenizer_macros.svh"

module stt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic [7:0]  text_byte_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [5:0]  token_kind_o,
  input wire logic [15:0] token_length_o,
  input wire logic [31:0] start_offset_o,
  input wire logic [15:0] start_line_o,
  input wire logic [15:0] start_column_o,
  input wire logic        last_of_run_o
);

  logic eof_out;
  logic stall_out;

  assign eof_out   = !empty && (token_kind_o == stt_pkg::KIND_EOF);
  assign stall_out = !empty && !pop;

  `STT_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stall_out, !empty && $stable(token_kind_o) && $stable(token_length_o) && $stable(start_offset_o) && $stable(last_of_run_o))
  `STT_ASSERT_IMPL(a_eof_shape, clk_i, rst_ni, eof_out, token_length_o == 16'd0 && last_of_run_o)
  `STT_ASSERT_IMPL(a_pos_nonzero, clk_i, rst_ni, !empty, start_line_o != 16'd0 && start_column_o != 16'd0)
  `STT_ASSERT_NEXT(a_eof_final, clk_i, rst_ni, eof_out && pop, empty)

  logic unused_in;
  assign unused_in = push ^ full ^ (^text_byte_i);

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire
